// ===== rtl/matrix_saddle_point_finder_assert.svh =====
// assertion macros used by the saddle point finder checker
`ifndef MATRIX_SADDLE_POINT_FINDER_ASSERT_SVH
`define MATRIX_SADDLE_POINT_FINDER_ASSERT_SVH

// a stalled channel keeps valid high and its payload stable
`define MSPF_ASSERT_HOLD(name, clk, rst_n, vld, rdy, data, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(data))) else $error(msg);

// plain implication checked at every clock edge out of reset
`define MSPF_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/msp_pkg.sv =====
// types, constants and codes of the saddle point finder
package msp_pkg;

  localparam int MAX_DIM     = 8;
  localparam int VALUE_BITS  = 32;
  localparam int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W      = 2 * DIM_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int FIELD_W     = 32;
  localparam int POS_W       = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  typedef logic [DIM_W-1:0]             idx_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_REPORT = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAX_SCAN,
    ST_PT_SCAN,
    ST_FLUSH
  } back_state_t;

  typedef struct packed {
    req_t                       req_type;
    logic signed [FIELD_W-1:0]  elem_value;
  } in_item_t;

  typedef struct packed {
    logic                       found;
    logic signed [FIELD_W-1:0]  point_value;
    logic [POS_W-1:0]           point_row;
    logic [POS_W-1:0]           point_col;
    logic                       last_result;
  } out_item_t;

  typedef struct packed {
    req_t   kind;
    idx_t   row;
    idx_t   col;
    value_t value;
  } cmd_t;

  typedef struct packed {
    idx_t rows_last;
    idx_t cols_last;
  } dim_t;

endpackage

// ===== rtl/msp_ram.sv =====
// generic single write port ram with registered read
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/msp_front.sv =====
// front end: config registers, load position and request classification
module msp_front import msp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 q_full,
  output logic                 push,
  output cmd_t                 push_cmd,
  output dim_t                 dims
);

  logic [CFG_W-1:0] row_count_r;
  logic [CFG_W-1:0] col_count_r;
  idx_t             pos_row_r, pos_row_nxt;
  idx_t             pos_col_r, pos_col_nxt;
  logic             accept;

  // clamp a count register to 1..MAX_DIM and return its last index
  function automatic idx_t dim_last(input logic [CFG_W-1:0] reg_val);
    if (reg_val == '0) begin
      return '0;
    end else if (int'(reg_val) > MAX_DIM) begin
      return idx_t'(MAX_DIM - 1);
    end else begin
      return idx_t'(reg_val - 1'b1);
    end
  endfunction

  assign in_ready       = !q_full;
  assign accept         = in_valid && in_ready;
  assign dims.rows_last = dim_last(row_count_r);
  assign dims.cols_last = dim_last(col_count_r);

  assign push           = accept;
  assign push_cmd.kind  = in_data.req_type;
  assign push_cmd.row   = pos_row_r;
  assign push_cmd.col   = pos_col_r;
  assign push_cmd.value = value_t'(in_data.elem_value);

  always_comb begin
    pos_row_nxt = pos_row_r;
    pos_col_nxt = pos_col_r;
    if (cfg_wr_en) begin
      pos_row_nxt = '0;
      pos_col_nxt = '0;
    end else if (accept) begin
      if (in_data.req_type == REQ_REPORT) begin
        pos_row_nxt = '0;
        pos_col_nxt = '0;
      end else if (pos_col_r == dims.cols_last) begin
        pos_col_nxt = '0;
        // wrap to a new matrix after the last element
        pos_row_nxt = (pos_row_r == dims.rows_last) ? '0 : pos_row_r + 1'b1;
      end else begin
        pos_col_nxt = pos_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= DIM_RESET;
      col_count_r <= DIM_RESET;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
    end else begin
      pos_row_r <= pos_row_nxt;
      pos_col_r <= pos_col_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ROW_COUNT: row_count_r <= cfg_wdata;
          CFG_COL_COUNT: col_count_r <= cfg_wdata;
        endcase
      end
    end
  end

endmodule

// ===== rtl/msp_queue.sv =====
// short command queue between front end and back end
module msp_queue import msp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/msp_back.sv =====
// back end: element writes, row/column trackers, report scan and result register
module msp_back import msp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_head,
  output logic              q_pop,
  input  dim_t              dims,
  output logic              ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output value_t            ram_wr_data,
  output logic              ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr,
  input  value_t            ram_rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  back_state_t state_r, state_nxt;

  // scan address counters
  idx_t      sr_r, sr_nxt;
  idx_t      sc_r, sc_nxt;
  logic      iss_done_r, iss_done_nxt;

  // read data stage
  logic      d_vld_r, d_vld_nxt;
  idx_t      d_row_r, d_row_nxt;
  idx_t      d_col_r, d_col_nxt;
  logic      d_last_r, d_last_nxt;

  value_t    row_max_r [MAX_DIM];
  value_t    col_min_r [MAX_DIM];

  // one saddle point held back until we know whether it is the last
  logic      pend_vld_r, pend_vld_nxt;
  out_item_t pend_r, pend_nxt;

  logic      out_vld_r, out_vld_nxt;
  out_item_t out_r, out_nxt;

  logic      trk_en;
  idx_t      trk_row;
  idx_t      trk_col;
  value_t    trk_val;
  logic      row_upd;
  logic      col_upd;
  logic      is_sp;
  logic      stall;
  logic      out_free;
  out_item_t sp_item;

  assign out_free    = !out_vld_r || out_ready;
  assign is_sp       = (ram_rd_data == row_max_r[d_row_r]) &&
                       (ram_rd_data == col_min_r[d_col_r]);
  assign ram_rd_addr = {sr_r, sc_r};
  assign ram_wr_addr = {q_head.row, q_head.col};
  assign ram_wr_data = q_head.value;
  assign out_valid   = out_vld_r;
  assign out_data    = out_r;

  always_comb begin
    sp_item             = '0;
    sp_item.found       = 1'b1;
    sp_item.point_value = FIELD_W'($unsigned(ram_rd_data));
    sp_item.point_row   = POS_W'(d_row_r);
    sp_item.point_col   = POS_W'(d_col_r);
  end

  always_comb begin
    state_nxt    = state_r;
    sr_nxt       = sr_r;
    sc_nxt       = sc_r;
    iss_done_nxt = iss_done_r;
    q_pop        = 1'b0;
    ram_wr_en    = 1'b0;
    ram_rd_en    = 1'b0;
    stall        = 1'b0;
    trk_en       = 1'b0;
    trk_row      = q_head.row;
    trk_col      = q_head.col;
    trk_val      = q_head.value;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_nxt      = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.kind == REQ_REPORT) begin
            state_nxt    = ST_MAX_SCAN;
            sr_nxt       = '0;
            sc_nxt       = '0;
            iss_done_nxt = 1'b0;
          end else begin
            ram_wr_en = 1'b1;
            trk_en    = 1'b1;
          end
        end
      end
      ST_MAX_SCAN: begin
        // first pass rebuilds row maxima and column minima from the store
        ram_rd_en = !iss_done_r;
        trk_en    = d_vld_r;
        trk_row   = d_row_r;
        trk_col   = d_col_r;
        trk_val   = ram_rd_data;
        if (d_vld_r && d_last_r) begin
          state_nxt    = ST_PT_SCAN;
          sr_nxt       = '0;
          sc_nxt       = '0;
          iss_done_nxt = 1'b0;
        end
      end
      ST_PT_SCAN: begin
        if (d_vld_r && is_sp) begin
          if (pend_vld_r) begin
            if (out_free) begin
              out_vld_nxt = 1'b1;
              out_nxt     = pend_r;
              pend_nxt    = sp_item;
            end else begin
              stall = 1'b1;
            end
          end else begin
            pend_vld_nxt = 1'b1;
            pend_nxt     = sp_item;
          end
        end
        ram_rd_en = !iss_done_r && !stall;
        if (d_vld_r && d_last_r && !stall) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          if (pend_vld_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt = '0;
          end
          out_nxt.last_result = 1'b1;
          pend_vld_nxt        = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end
    endcase

    if (ram_rd_en) begin
      if (sc_r == dims.cols_last) begin
        sc_nxt = '0;
        if (sr_r == dims.rows_last) begin
          iss_done_nxt = 1'b1;
        end else begin
          sr_nxt = sr_r + 1'b1;
        end
      end else begin
        sc_nxt = sc_r + 1'b1;
      end
    end
  end

  // read stage holds together with the ram output while stalled
  always_comb begin
    d_vld_nxt  = d_vld_r;
    d_row_nxt  = d_row_r;
    d_col_nxt  = d_col_r;
    d_last_nxt = d_last_r;
    if (ram_rd_en) begin
      d_vld_nxt  = 1'b1;
      d_row_nxt  = sr_r;
      d_col_nxt  = sc_r;
      d_last_nxt = (sr_r == dims.rows_last) && (sc_r == dims.cols_last);
    end else if (!stall) begin
      d_vld_nxt = 1'b0;
    end
  end

  // tracker starts at the first element of its row or column
  assign row_upd = trk_en && ((trk_col == '0) || (trk_val > row_max_r[trk_row]));
  assign col_upd = trk_en && ((trk_row == '0) || (trk_val < col_min_r[trk_col]));

  always_ff @(posedge clk) begin
    if (row_upd) begin
      row_max_r[trk_row] <= trk_val;
    end
    if (col_upd) begin
      col_min_r[trk_col] <= trk_val;
    end
  end

  always_ff @(posedge clk) begin
    d_row_r  <= d_row_nxt;
    d_col_r  <= d_col_nxt;
    d_last_r <= d_last_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      sr_r       <= '0;
      sc_r       <= '0;
      iss_done_r <= 1'b1;
      d_vld_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sr_r       <= sr_nxt;
      sc_r       <= sc_nxt;
      iss_done_r <= iss_done_nxt;
      d_vld_r    <= d_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

endmodule

// ===== rtl/matrix_saddle_point_finder.sv =====
// Saddle point finder top level. Load requests are taken back to back while the queue has room:
// the front end assigns the row-major position and a two-entry queue feeds the back end, which
// writes the element store and the running row maximum and column minimum together.
// A report request is carried out by the back end in two passes over the stored
// rows x cols elements through the single read port of the element store: the first
// rebuilds the row maxima and column minima, the second emits every saddle point in
// row-major order. A report is held up whenever out_ready holds a result back, and loads
// queued behind it wait until it finishes.
// A report with no saddle point yields one result with found low and last_result high.
// Configuration writes restart loading at the first element and must be made only while idle.
module matrix_saddle_point_finder import msp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic              push;
  cmd_t              push_cmd;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  cmd_t              q_head;
  dim_t              dims;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  value_t            ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  value_t            ram_rd_data;

  msp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .dims      (dims)
  );

  msp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  msp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .dims        (dims),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  msp_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

// ===== rtl/msp_checker.sv =====
// port-level checker for the saddle point finder and its bind
`include "matrix_saddle_point_finder_assert.svh"

module msp_checker import msp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `MSPF_ASSERT_HOLD(a_in_hold, clk, rst_n, in_valid, in_ready, in_data, "request changed while stalled")
  `MSPF_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_data, "result changed while stalled")
  `MSPF_ASSERT_IMPL(a_none_is_last, clk, rst_n, out_valid && !out_data.found, out_data.last_result, "no-saddle result not marked last")
  `MSPF_ASSERT_IMPL(a_none_is_zero, clk, rst_n, out_valid && !out_data.found, (out_data.point_value == '0) && (out_data.point_row == '0) && (out_data.point_col == '0), "no-saddle result carries nonzero fields")

endmodule

bind matrix_saddle_point_finder msp_checker u_msp_checker (.*);

// ===== dv/tb.sv =====
// self-checking testbench for the matrix saddle point finder
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msp_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int LIMIT_CYCLES = 500000;
  localparam int LOAD_SETTLE  = 12;
  localparam int END_SETTLE   = 2 * MAX_DIM * MAX_DIM + 40;
  localparam int RANDOM_ITEMS = 400;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // matrix as the block should hold it
  value_t           cells [MAX_DIM*MAX_DIM];
  logic [CFG_W-1:0] rows_cfg = DIM_RESET;
  logic [CFG_W-1:0] cols_cfg = DIM_RESET;
  int               load_pos = 0;
  out_item_t        pending_points [$];

  int cycle_count = 0;
  int errors = 0;
  int requests_sent = 0;
  int reports_sent = 0;
  int results_seen = 0;
  int points_seen = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int ready_phase = 0;

  matrix_saddle_point_finder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_points.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int dim_in_use(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // store a load, or scan the matrix and queue every saddle point of a report (or one no-saddle result)
  task automatic apply_request(input in_item_t item);
    int        rows;
    int        cols;
    int        r;
    int        c;
    value_t    row_top [MAX_DIM];
    value_t    col_low [MAX_DIM];
    value_t    v;
    out_item_t res;
    out_item_t batch [$];
    rows = dim_in_use(rows_cfg);
    cols = dim_in_use(cols_cfg);
    if (item.req_type == REQ_LOAD) begin
      if (load_pos >= rows * cols) load_pos = 0;
      r = load_pos / cols;
      c = load_pos % cols;
      cells[r*MAX_DIM + c] = item.elem_value;
      load_pos++;
    end else begin
      for (r = 0; r < rows; r++) begin
        row_top[r] = cells[r*MAX_DIM];
        for (c = 1; c < cols; c++)
          if (cells[r*MAX_DIM + c] > row_top[r]) row_top[r] = cells[r*MAX_DIM + c];
      end
      for (c = 0; c < cols; c++) begin
        col_low[c] = cells[c];
        for (r = 1; r < rows; r++)
          if (cells[r*MAX_DIM + c] < col_low[c]) col_low[c] = cells[r*MAX_DIM + c];
      end
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < cols; c++) begin
          v = cells[r*MAX_DIM + c];
          if (v == row_top[r] && v == col_low[c]) begin
            res.found       = 1'b1;
            res.point_value = v;
            res.point_row   = POS_W'(r);
            res.point_col   = POS_W'(c);
            res.last_result = 1'b0;
            batch.push_back(res);
          end
        end
      end
      if (batch.size() == 0) begin
        res = '0;
        res.last_result = 1'b1;
        batch.push_back(res);
      end else begin
        batch[batch.size()-1].last_result = 1'b1;
      end
      foreach (batch[i]) pending_points.push_back(batch[i]);
      load_pos = 0;
      reports_sent++;
    end
  endtask

  // sender: bursts of back-to-back requests with random gaps between them
  task automatic send_request(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    requests_sent++;
    apply_request(item);
  endtask

  task automatic send_load(input value_t v);
    in_item_t item;
    item.req_type   = REQ_LOAD;
    item.elem_value = v;
    send_request(item);
  endtask

  task automatic send_report();
    in_item_t item;
    item.req_type   = REQ_REPORT;
    item.elem_value = $urandom();
    send_request(item);
  endtask

  // hold off until every expected result is back and queued loads have landed
  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ROW_COUNT) rows_cfg = v;
    else cols_cfg = v;
    load_pos = 0;
    cfg_writes++;
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    drain_results(LOAD_SETTLE);
    write_cfg(CFG_ROW_COUNT, rows);
    write_cfg(CFG_COL_COUNT, cols);
  endtask

  // element that keeps (r0, c0) a saddle point: smaller along its row, larger down its column
  function automatic value_t planted_value(int r, int c, int r0, int c0, value_t anchor);
    value_t v;
    if (r == r0 && c == c0) v = anchor;
    else if (r == r0) v = anchor - value_t'($urandom_range(1, 50));
    else if (c == c0) v = anchor + value_t'($urandom_range(1, 50));
    else v = value_t'($urandom_range(0, 4000)) - 2000;
    return v;
  endfunction

  // checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.found) points_seen++;
      if (pending_points.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: found=%0d value=%0d row=%0d col=%0d last=%0d",
                   out_data.found, out_data.point_value, out_data.point_row,
                   out_data.point_col, out_data.last_result);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (out_data.found !== want.found || out_data.point_value !== want.point_value ||
            out_data.point_row !== want.point_row || out_data.point_col !== want.point_col ||
            out_data.last_result !== want.last_result) begin
          if (errors < 10) begin
            $display("mismatch at cycle %0d: expected found=%0d value=%0d row=%0d col=%0d last=%0d",
                     cycle_count, want.found, want.point_value, want.point_row,
                     want.point_col, want.last_result);
            $display("  got found=%0d value=%0d row=%0d col=%0d last=%0d",
                     out_data.found, out_data.point_value, out_data.point_row,
                     out_data.point_col, out_data.last_result);
          end
          errors++;
        end
      end
    end
  end

  // receiver stalls, switching between free flow, random, periodic and heavy back-pressure
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end
    stall_left--;
    ready_phase++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      2: out_ready <= (ready_phase % 4 != 3);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // reset dimensions are 8 x 8; filling all of it also writes every store entry
  task automatic test_default_dims();
    int     r0;
    int     c0;
    value_t anchor;
    r0 = $urandom_range(0, MAX_DIM - 1);
    c0 = $urandom_range(0, MAX_DIM - 1);
    anchor = value_t'($urandom_range(0, 2000)) - 1000;
    for (int r = 0; r < MAX_DIM; r++)
      for (int c = 0; c < MAX_DIM; c++)
        send_load(planted_value(r, c, r0, c0, anchor));
    send_report();
  endtask

  task automatic test_value_extremes();
    set_dims(1, 2);
    send_load(32'sh8000_0000);
    send_load(32'sh7fff_ffff);
    send_report();
    set_dims(2, 1);
    send_load(32'sh7fff_ffff);
    send_load(32'sh8000_0000);
    send_report();
  endtask

  // zero acts as one, anything above the maximum acts as the maximum
  task automatic test_dim_clamping();
    set_dims(0, 0);
    send_load($urandom());
    send_report();
    set_dims(15, 15);
    send_report();
  endtask

  task automatic test_no_saddle();
    set_dims(2, 2);
    send_load(1);
    send_load(2);
    send_load(2);
    send_load(1);
    send_report();
  endtask

  task automatic test_tied_saddles();
    set_dims(2, 2);
    repeat (4) send_load(-5);
    send_report();
  endtask

  // load past the end wraps; report and register writes restart at the first element
  task automatic test_wrap_and_restart();
    set_dims(1, 2);
    send_load(10);
    send_load(20);
    send_load(5);
    send_report();
    send_report();
    send_load(30);
    drain_results(LOAD_SETTLE);
    write_cfg(CFG_COL_COUNT, 2);
    send_load(1);
    send_report();
  endtask

  task automatic test_random_matrices();
    int     items;
    int     round;
    int     rows;
    int     cols;
    int     loads;
    int     mode;
    int     p;
    int     r;
    int     c;
    int     r0;
    int     c0;
    bit     broken;
    value_t anchor;
    value_t v;
    items = 0;
    round = 0;
    while (items < RANDOM_ITEMS) begin
      round++;
      if ($urandom_range(0, 3) == 0) begin
        drain_results(LOAD_SETTLE);
        if ($urandom_range(0, 2) != 0)
          write_cfg(CFG_ROW_COUNT,
                    CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 4)));
        if ($urandom_range(0, 2) != 0)
          write_cfg(CFG_COL_COUNT,
                    CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 4)));
      end else if (round % 8 == 0) begin
        drain_results(LOAD_SETTLE);
      end
      rows = dim_in_use(rows_cfg);
      cols = dim_in_use(cols_cfg);
      broken = ($urandom_range(0, 4) == 0);
      loads = broken ? $urandom_range(0, rows * cols + 4) : rows * cols;
      mode = $urandom_range(0, 4);
      r0 = $urandom_range(0, rows - 1);
      c0 = $urandom_range(0, cols - 1);
      anchor = value_t'($urandom_range(0, 2000)) - 1000;
      for (int k = 0; k < loads; k++) begin
        p = k % (rows * cols);
        r = p / cols;
        c = p % cols;
        case (mode)
          0: v = $urandom();
          1: v = value_t'($urandom_range(0, 4)) - 2;
          2: v = planted_value(r, c, r0, c0, anchor);
          3: v = anchor;
          default: begin
            case ($urandom_range(0, 3))
              0: v = 32'sh8000_0000;
              1: v = 32'sh7fff_ffff;
              2: v = 0;
              default: v = -1;
            endcase
          end
        endcase
        send_load(v);
        items++;
      end
      send_report();
      items++;
      if (broken && $urandom_range(0, 1) == 1) begin
        send_report();
        items++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_dims();
    test_value_extremes();
    test_dim_clamping();
    test_no_saddle();
    test_tied_saddles();
    test_wrap_and_restart();
    test_random_matrices();
    drain_results(END_SETTLE);
    if (pending_points.size() != 0) errors++;
    $display("sent %0d requests (%0d reports) over %0d register writes", requests_sent,
             reports_sent, cfg_writes);
    $display("checked %0d results holding %0d saddle points, %0d failures", results_seen,
             points_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== matrix_saddle_point_finder.f =====
+incdir+rtl
rtl/msp_pkg.sv
rtl/msp_ram.sv
rtl/msp_front.sv
rtl/msp_queue.sv
rtl/msp_back.sv
rtl/matrix_saddle_point_finder.sv
rtl/msp_checker.sv
dv/tb.sv
